/* hw/rtl/grid_component_labeler_assert.svh */
// ----------------------------------------------------------------------------
// Grid component labeler assertion macros
// Concurrent checks on a clock with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef GRID_COMPONENT_LABELER_ASSERT_SVH
`define GRID_COMPONENT_LABELER_ASSERT_SVH

// same-cycle implication
`define GCL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gcl_pkg.sv */
// ----------------------------------------------------------------------------
// Grid component labeler package
// Field widths, operation and register codes, controller command and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcl_pkg;

    localparam int FUNC_W      = 2;
    localparam int COORD_W     = 6;
    localparam int FIELD_W     = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int IN_X_LSB    = 0;
    localparam int IN_Z_LSB    = 6;
    localparam int IN_OCC_BIT  = 12;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXCL_EN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXCL_X  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXCL_Z  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic sweep_occ;
        logic sweep_lbl;
        logic occ_wr;
        logic rd_cell;
        logic scan_rd;
        logic scan_adv;
        logic seed;
        logic pop_rd;
        logic nb_rd;
        logic nb_adv;
        logic nb_mark;
        logic cnt_clr;
        logic valid_set;
        logic push;
        logic push_label;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic scan_last;
        logic cand;
        logic q_empty;
        logic nb_ok;
        logic nb_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/gcl_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hw/rtl/gcl_ctrl.sv */
// ----------------------------------------------------------------------------
// Grid component labeler controller
// Sequences cell writes, label reads and the clear/scan/flood-fill run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [gcl_pkg::FUNC_W-1:0]  i_in_func,
    output logic                        o_in_ready,
    input  gcl_pkg::t_status            i_status,
    output gcl_pkg::t_cmd               o_cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_WRITE    = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_RESULT   = 4'd4;
    localparam logic [3:0] S_CLEAR    = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_CHK = 4'd7;
    localparam logic [3:0] S_POP      = 4'd8;
    localparam logic [3:0] S_NB_RD    = 4'd9;
    localparam logic [3:0] S_NB_CHK   = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_is_read;
    logic       n_is_read;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_is_read = r_is_read;
        o_cmd     = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_occ = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_is_read     = (i_in_func == gcl_pkg::FUNC_READ);
                    case (i_in_func)
                        gcl_pkg::FUNC_WRITE: n_state = S_WRITE;
                        gcl_pkg::FUNC_RUN: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        gcl_pkg::FUNC_READ: n_state = S_READ;
                        default: n_state = S_RESULT;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.occ_wr = 1'b1;
                n_state      = S_RESULT;
            end
            S_READ: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.push_label = r_is_read;
                    n_state          = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_lbl = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_status.cand) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_POP;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = i_status.scan_last ? S_FINISH : S_SCAN_RD;
                end
            end
            S_POP: begin
                if (i_status.q_empty) begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = i_status.scan_last ? S_FINISH : S_SCAN_RD;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_NB_RD;
                end
            end
            S_NB_RD: begin
                if (i_status.nb_ok) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state     = S_NB_CHK;
                end else begin
                    o_cmd.nb_adv = 1'b1;
                    n_state      = i_status.nb_last ? S_POP : S_NB_RD;
                end
            end
            S_NB_CHK: begin
                o_cmd.nb_mark = i_status.cand;
                o_cmd.nb_adv  = 1'b1;
                n_state       = i_status.nb_last ? S_POP : S_NB_RD;
            end
            S_FINISH: begin
                o_cmd.valid_set = 1'b1;
                n_state         = S_RESULT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_read <= n_is_read;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gcl_datapath.sv */
// ----------------------------------------------------------------------------
// Grid component labeler datapath
// Occupancy, label and search queue memories with scan, fill and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcl_datapath #(
    parameter int GRID_SIDE = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [gcl_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gcl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [gcl_pkg::COORD_W-1:0]       i_x,
    input  logic [gcl_pkg::COORD_W-1:0]       i_z,
    input  logic                              i_occupied,
    input  gcl_pkg::t_cmd                     i_cmd,
    output gcl_pkg::t_status                  o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [gcl_pkg::FIELD_W-1:0]       o_label,
    output logic [gcl_pkg::FIELD_W-1:0]       o_count
);

    localparam int CW     = $clog2(GRID_SIDE);
    localparam int AW     = 2 * CW;
    localparam int DEPTH  = 1 << AW;
    localparam int CNT_W  = $clog2(GRID_SIDE * GRID_SIDE / 2 + 2);
    localparam int LBL_W  = (CNT_W > gcl_pkg::FIELD_W) ? CNT_W : gcl_pkg::FIELD_W;
    localparam int CMP_W  = ((CW > gcl_pkg::COORD_W) ? CW : gcl_pkg::COORD_W) + 1;
    localparam logic [CW-1:0]    SIDE_LAST = CW'(GRID_SIDE - 1);
    localparam logic [CMP_W-1:0] SIDE_CMP  = CMP_W'(GRID_SIDE);

    localparam logic [1:0] NB_XP = 2'd0;
    localparam logic [1:0] NB_ZP = 2'd1;
    localparam logic [1:0] NB_XM = 2'd2;
    localparam logic [1:0] NB_ZM = 2'd3;

    logic                        r_excl_en;
    logic [gcl_pkg::COORD_W-1:0] r_excl_x;
    logic [gcl_pkg::COORD_W-1:0] r_excl_z;
    logic [gcl_pkg::COORD_W-1:0] r_x;
    logic [gcl_pkg::COORD_W-1:0] r_z;
    logic                        r_occ;
    logic [AW-1:0]               r_sweep;
    logic [CW-1:0]               r_sx;
    logic [CW-1:0]               r_sz;
    logic [AW:0]                 r_head;
    logic [AW:0]                 r_tail;
    logic [1:0]                  r_nb;
    logic [AW-1:0]               r_rd_addr;
    logic [LBL_W-1:0]            r_count;
    logic                        r_lbl_valid;
    logic                        r_hit;
    logic                        r_out_valid;
    logic [gcl_pkg::FIELD_W-1:0] r_out_label;
    logic [gcl_pkg::FIELD_W-1:0] r_out_count;

    logic [CMP_W-1:0] in_xe;
    logic [CMP_W-1:0] in_ze;
    logic             in_grid;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    scan_addr;
    logic [AW-1:0]    q_rd_data;
    logic [CW-1:0]    cur_x;
    logic [CW-1:0]    cur_z;
    logic [CW-1:0]    nb_x;
    logic [CW-1:0]    nb_z;
    logic             nb_ok;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             occ_q;
    logic [LBL_W-1:0] lbl_q;
    logic [LBL_W-1:0] count_inc;
    logic             excl_hit;
    logic             scan_last;

    logic             occ_wr_en;
    logic [AW-1:0]    occ_wr_addr;
    logic             occ_wr_data;
    logic             lbl_wr_en;
    logic [AW-1:0]    lbl_wr_addr;
    logic [LBL_W-1:0] lbl_wr_data;
    logic             q_wr_en;
    logic [AW-1:0]    q_wr_addr;

    assign in_xe     = CMP_W'(r_x);
    assign in_ze     = CMP_W'(r_z);
    assign in_grid   = (in_xe < SIDE_CMP) && (in_ze < SIDE_CMP);
    assign in_addr   = {in_ze[CW-1:0], in_xe[CW-1:0]};
    assign scan_addr = {r_sz, r_sx};
    assign scan_last = (r_sx == SIDE_LAST) && (r_sz == SIDE_LAST);
    assign cur_x     = q_rd_data[CW-1:0];
    assign cur_z     = q_rd_data[AW-1:CW];
    assign count_inc = r_count + 1'b1;

    always_comb begin
        nb_x  = cur_x;
        nb_z  = cur_z;
        nb_ok = 1'b0;
        case (r_nb)
            NB_XP: begin
                nb_x  = cur_x + 1'b1;
                nb_ok = (cur_x != SIDE_LAST);
            end
            NB_ZP: begin
                nb_z  = cur_z + 1'b1;
                nb_ok = (cur_z != SIDE_LAST);
            end
            NB_XM: begin
                nb_x  = cur_x - 1'b1;
                nb_ok = (cur_x != '0);
            end
            NB_ZM: begin
                nb_z  = cur_z - 1'b1;
                nb_ok = (cur_z != '0);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign rd_en = i_cmd.scan_rd | i_cmd.nb_rd | i_cmd.rd_cell;

    always_comb begin
        if (i_cmd.scan_rd) begin
            rd_addr = scan_addr;
        end else if (i_cmd.nb_rd) begin
            rd_addr = {nb_z, nb_x};
        end else begin
            rd_addr = in_addr;
        end
    end

    assign excl_hit = r_excl_en
                   && (CMP_W'(r_rd_addr[CW-1:0]) == CMP_W'(r_excl_x))
                   && (CMP_W'(r_rd_addr[AW-1:CW]) == CMP_W'(r_excl_z));

    assign occ_wr_en   = i_cmd.sweep_occ | (i_cmd.occ_wr & in_grid);
    assign occ_wr_addr = i_cmd.sweep_occ ? r_sweep : in_addr;
    assign occ_wr_data = i_cmd.sweep_occ ? 1'b0 : r_occ;

    assign lbl_wr_en   = i_cmd.sweep_lbl | i_cmd.seed | i_cmd.nb_mark;
    assign lbl_wr_addr = i_cmd.sweep_lbl ? r_sweep : r_rd_addr;
    assign lbl_wr_data = i_cmd.sweep_lbl ? '0 : (i_cmd.seed ? count_inc : r_count);

    assign q_wr_en   = i_cmd.seed | i_cmd.nb_mark;
    assign q_wr_addr = i_cmd.seed ? '0 : r_tail[AW-1:0];

    gcl_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .i_clk     (i_clk),
        .i_wr_en   (occ_wr_en),
        .i_wr_addr (occ_wr_addr),
        .i_wr_data (occ_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (occ_q)
    );

    gcl_ram #(
        .WIDTH (LBL_W),
        .DEPTH (DEPTH)
    ) u_lbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lbl_wr_en),
        .i_wr_addr (lbl_wr_addr),
        .i_wr_data (lbl_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (lbl_q)
    );

    gcl_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (r_rd_addr),
        .i_rd_en   (i_cmd.pop_rd),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (q_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl_en   <= 1'b0;
            r_excl_x    <= '0;
            r_excl_z    <= '0;
            r_sweep     <= '0;
            r_sx        <= '0;
            r_sz        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_nb        <= NB_XP;
            r_count     <= '0;
            r_lbl_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    gcl_pkg::CFG_EXCL_EN: r_excl_en <= i_cfg_wdata[0];
                    gcl_pkg::CFG_EXCL_X:  r_excl_x  <= i_cfg_wdata;
                    gcl_pkg::CFG_EXCL_Z:  r_excl_z  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.sweep_occ || i_cmd.sweep_lbl) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.scan_adv) begin
                if (r_sx == SIDE_LAST) begin
                    r_sx <= '0;
                    r_sz <= (r_sz == SIDE_LAST) ? '0 : r_sz + 1'b1;
                end else begin
                    r_sx <= r_sx + 1'b1;
                end
            end
            if (i_cmd.seed) begin
                r_head <= '0;
                r_tail <= (AW+1)'(1);
            end else begin
                if (i_cmd.pop_rd) begin
                    r_head <= r_head + 1'b1;
                end
                if (i_cmd.nb_mark) begin
                    r_tail <= r_tail + 1'b1;
                end
            end
            if (i_cmd.nb_adv) begin
                r_nb <= r_nb + 1'b1;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.seed) begin
                r_count <= count_inc;
            end
            if (i_cmd.occ_wr && in_grid) begin
                r_lbl_valid <= 1'b0;
            end else if (i_cmd.valid_set) begin
                r_lbl_valid <= 1'b1;
            end
            if (i_cmd.rd_cell) begin
                r_hit <= r_lbl_valid && in_grid;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x   <= i_x;
            r_z   <= i_z;
            r_occ <= i_occupied;
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.push) begin
            r_out_label <= (i_cmd.push_label && r_hit) ? lbl_q[gcl_pkg::FIELD_W-1:0] : '0;
            r_out_count <= r_count[gcl_pkg::FIELD_W-1:0];
        end
    end

    assign o_status.sweep_last = &r_sweep;
    assign o_status.scan_last  = scan_last;
    assign o_status.cand       = occ_q && (lbl_q == '0) && !excl_hit;
    assign o_status.q_empty    = (r_head == r_tail);
    assign o_status.nb_ok      = nb_ok;
    assign o_status.nb_last    = (r_nb == NB_ZM);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_label     = r_out_label;
    assign o_count     = r_out_count;

endmodule

`default_nettype wire

/* hw/rtl/grid_component_labeler.sv */
// Writes pass a write state, reads a read state, unused codes go straight to the result.
// Labeling run: a clear sweep over all S label cells, a read and check per cell scanned,
// a seed per component, per labeled cell a pop and a read and check per in-grid neighbour,
// then finish; S = 4^ceil(log2(GRID_SIDE)), 4096 at the default. Run length is set by the
// read address shared by the occupancy and label memories. Reset clears control, then a
// clearing sweep of all S occupancy cells with o_s_tready low; config writes taken during it.
// ----------------------------------------------------------------------------
// Grid component labeler
// 4-connected component labeling of an occupancy grid by breadth-first fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_component_labeler_assert.svh"

module grid_component_labeler #(
    parameter int GRID_SIDE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gcl_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [gcl_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // x [5:0], z [11:6], occupied [12], zero [15:13]
    input  logic [gcl_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // func [1:0]
    input  logic [gcl_pkg::FUNC_W-1:0]          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // label [11:0], component_count [23:12]
    output logic [gcl_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);

    gcl_pkg::t_cmd               cmd;
    gcl_pkg::t_status            status;
    logic [gcl_pkg::FIELD_W-1:0] out_label;
    logic [gcl_pkg::FIELD_W-1:0] out_count;

    gcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_func  (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gcl_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_x         (i_s_tdata[gcl_pkg::IN_X_LSB +: gcl_pkg::COORD_W]),
        .i_z         (i_s_tdata[gcl_pkg::IN_Z_LSB +: gcl_pkg::COORD_W]),
        .i_occupied  (i_s_tdata[gcl_pkg::IN_OCC_BIT]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_label     (out_label),
        .o_count     (out_count)
    );

    assign o_m_tdata = {out_count, out_label};

    `GCL_ASSERT_NOW(a_push_free, i_clk, i_rst_n, cmd.push, status.out_free, "result pushed over an untaken transfer")
    `GCL_ASSERT_NEXT(a_push_valid, i_clk, i_rst_n, cmd.push, o_m_tvalid, "pushed result not presented")
    `GCL_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, cmd.pop_rd, !status.q_empty, "pop from empty search queue")
    `GCL_ASSERT_NEXT(a_write_issue, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tuser == gcl_pkg::FUNC_WRITE), cmd.occ_wr, "cell write not issued after transfer")

endmodule

`default_nettype wire

/* bench/grid_component_labeler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid component labeler testbench
// Drives cell writes, labeling runs and label reads through the stream ports
// and changes the excluded cell between phases. A flood-fill tracker keeps its
// own occupancy grid and labels, and every result transfer is checked in order
// against the answer the tracker predicted for the accepted command.
// ----------------------------------------------------------------------------

module grid_component_labeler_tb;

    localparam int GRID_SIDE = 64;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam logic [gcl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [gcl_pkg::FIELD_W-1:0] label;
        logic [gcl_pkg::FIELD_W-1:0] count;
    } t_label_answer;

    class t_label_tracker;
        bit                          occupancy[CELLS];
        logic [gcl_pkg::FIELD_W-1:0] labels[CELLS];
        int                          found;
        bit                          labels_ready;
        bit                          excl_en;
        logic [gcl_pkg::COORD_W-1:0] excl_x;
        logic [gcl_pkg::COORD_W-1:0] excl_z;
        t_label_answer               pending_answers[$];
        int                          faults;

        function void set_reg(input logic [gcl_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [gcl_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                gcl_pkg::CFG_EXCL_EN: excl_en = val[0];
                gcl_pkg::CFG_EXCL_X:  excl_x  = val[gcl_pkg::COORD_W-1:0];
                gcl_pkg::CFG_EXCL_Z:  excl_z  = val[gcl_pkg::COORD_W-1:0];
                default: ;
            endcase
        endfunction

        function bit member(int pos);
            if (excl_en && pos == int'({excl_z, excl_x}))
                return 1'b0;
            return occupancy[pos];
        endfunction

        function void grow(int pos, ref int frontier[$]);
            if (member(pos) && labels[pos] == '0) begin
                labels[pos] = gcl_pkg::FIELD_W'(found);
                frontier.push_back(pos);
            end
        endfunction

        function void apply_command(input logic [gcl_pkg::FUNC_W-1:0] fn,
                                    input logic [gcl_pkg::COORD_W-1:0] x,
                                    input logic [gcl_pkg::COORD_W-1:0] z,
                                    input logic occ);
            t_label_answer ans;
            int            frontier[$];
            int            pos;
            int            cx;
            int            cz;
            ans.label = '0;
            case (fn)
                gcl_pkg::FUNC_WRITE: begin
                    occupancy[{z, x}] = occ;
                    labels_ready = 1'b0;
                end
                gcl_pkg::FUNC_RUN: begin
                    foreach (labels[i])
                        labels[i] = '0;
                    found = 0;
                    // raster order: row outer, column inner
                    for (int seed = 0; seed < CELLS; seed++) begin
                        if (!member(seed) || labels[seed] != '0)
                            continue;
                        found++;
                        grow(seed, frontier);
                        while (frontier.size() > 0) begin
                            pos = frontier.pop_front();
                            cx = pos % GRID_SIDE;
                            cz = pos / GRID_SIDE;
                            if (cx < GRID_SIDE - 1) grow(pos + 1, frontier);
                            if (cz < GRID_SIDE - 1) grow(pos + GRID_SIDE, frontier);
                            if (cx > 0) grow(pos - 1, frontier);
                            if (cz > 0) grow(pos - GRID_SIDE, frontier);
                        end
                    end
                    labels_ready = 1'b1;
                end
                gcl_pkg::FUNC_READ: begin
                    if (labels_ready)
                        ans.label = labels[{z, x}];
                end
                default: ;
            endcase
            ans.count = gcl_pkg::FIELD_W'(found);
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(input logic [gcl_pkg::OUT_TDATA_W-1:0] data);
            t_label_answer want;
            if (pending_answers.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result transfer: label %0d count %0d",
                             data[gcl_pkg::FIELD_W-1:0],
                             data[2*gcl_pkg::FIELD_W-1:gcl_pkg::FIELD_W]);
                return;
            end
            want = pending_answers.pop_front();
            if (data[gcl_pkg::FIELD_W-1:0] !== want.label
                    || data[2*gcl_pkg::FIELD_W-1:gcl_pkg::FIELD_W] !== want.count) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: label exp %0d got %0d, count exp %0d got %0d",
                             want.label, data[gcl_pkg::FIELD_W-1:0],
                             want.count, data[2*gcl_pkg::FIELD_W-1:gcl_pkg::FIELD_W]);
            end
        endfunction
    endclass

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [gcl_pkg::CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [gcl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [gcl_pkg::IN_TDATA_W-1:0]    i_s_tdata   = '0;
    logic [gcl_pkg::FUNC_W-1:0]        i_s_tuser   = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [gcl_pkg::OUT_TDATA_W-1:0]   o_m_tdata;

    t_label_tracker tracker = new();
    bit idle_on      = 1'b1;
    bit stall_on     = 1'b1;
    bit hold_request = 1'b0;

    grid_component_labeler #(
        .GRID_SIDE(GRID_SIDE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(50_000_000);
        $display("grid_component_labeler_tb NOT OK");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                tracker.check_answer(o_m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 400;
            end else if (hold == 0 && stall_on && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 8);
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [gcl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gcl_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic send_item(input logic [gcl_pkg::FUNC_W-1:0] fn,
                             input logic [gcl_pkg::COORD_W-1:0] x,
                             input logic [gcl_pkg::COORD_W-1:0] z,
                             input logic occ);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= gcl_pkg::IN_TDATA_W'({occ, z, x});
        i_s_tuser  <= fn;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        tracker.apply_command(fn, x, z, occ);
    endtask

    // drop valid and hold until every answer is back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (tracker.pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [gcl_pkg::COORD_W-1:0] pick_coord(input int base);
        case ($urandom_range(0, 9))
            0:       return gcl_pkg::COORD_W'($urandom_range(0, GRID_SIDE - 1));
            1:       return gcl_pkg::COORD_W'($urandom_range(0, 7) + GRID_SIDE - 4);
            default: return gcl_pkg::COORD_W'(base + $urandom_range(0, 7));
        endcase
    endfunction

    task automatic noise_item();
        send_item(gcl_pkg::FUNC_W'($urandom_range(0, 3)), gcl_pkg::COORD_W'($urandom()),
                  gcl_pkg::COORD_W'($urandom()), 1'($urandom()));
    endtask

    // fill part of the grid, label it, then read labels back
    task automatic grid_episode(input int base);
        int n_writes;
        int n_reads;
        int occ_pct;
        n_writes = $urandom_range(6, 26);
        n_reads  = $urandom_range(6, 18);
        occ_pct  = $urandom_range(30, 85);
        repeat (n_writes) begin
            if ($urandom_range(0, 19) == 0)
                noise_item();
            else
                send_item(gcl_pkg::FUNC_WRITE, pick_coord(base), pick_coord(base),
                          $urandom_range(0, 99) < occ_pct);
        end
        send_item(gcl_pkg::FUNC_RUN, gcl_pkg::COORD_W'($urandom()),
                  gcl_pkg::COORD_W'($urandom()), 1'($urandom()));
        repeat (n_reads) begin
            if ($urandom_range(0, 19) == 0)
                noise_item();
            else
                send_item(gcl_pkg::FUNC_READ, pick_coord(base), pick_coord(base),
                          1'($urandom()));
        end
    endtask

    initial begin
        int base;
        logic excl_en;
        logic [gcl_pkg::COORD_W-1:0] excl_x;
        logic [gcl_pkg::COORD_W-1:0] excl_z;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: read before any labeling, unused code, corners, edge pairs
        send_item(gcl_pkg::FUNC_READ,  6'd0,  6'd0,  1'b0);
        send_item(FUNC_UNUSED,         6'd63, 6'd63, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd0,  6'd0,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd63, 6'd0,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd0,  6'd63, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd63, 6'd10, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd0,  6'd10, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd20, 6'd63, 1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd20, 6'd0,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd5,  6'd5,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd6,  6'd5,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd6,  6'd6,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd7,  6'd7,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd9,  6'd9,  1'b1);
        send_item(gcl_pkg::FUNC_WRITE, 6'd9,  6'd9,  1'b0);
        send_item(gcl_pkg::FUNC_RUN,   6'd0,  6'd0,  1'b0);
        send_item(gcl_pkg::FUNC_READ,  6'd6,  6'd6,  1'b0);
        send_item(gcl_pkg::FUNC_READ,  6'd63, 6'd10, 1'b0);
        send_item(gcl_pkg::FUNC_READ,  6'd20, 6'd63, 1'b0);
        send_item(gcl_pkg::FUNC_READ,  6'd9,  6'd9,  1'b0);
        send_item(FUNC_UNUSED,         6'd6,  6'd6,  1'b0);
        send_item(gcl_pkg::FUNC_WRITE, 6'd40, 6'd40, 1'b0);
        send_item(gcl_pkg::FUNC_READ,  6'd6,  6'd6,  1'b0);

        // excluding the corner of the L splits it in two
        settle();
        write_reg(gcl_pkg::CFG_EXCL_X,  gcl_pkg::CFG_DATA_W'(6));
        write_reg(gcl_pkg::CFG_EXCL_Z,  gcl_pkg::CFG_DATA_W'(5));
        write_reg(gcl_pkg::CFG_EXCL_EN, gcl_pkg::CFG_DATA_W'(1));
        send_item(gcl_pkg::FUNC_RUN,  6'd0, 6'd0, 1'b0);
        send_item(gcl_pkg::FUNC_READ, 6'd6, 6'd5, 1'b0);
        send_item(gcl_pkg::FUNC_READ, 6'd5, 6'd5, 1'b0);
        send_item(gcl_pkg::FUNC_READ, 6'd6, 6'd6, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin excl_en = 1'b0; excl_x = 6'd0;  excl_z = 6'd0;  base = 0;  end
                1: begin excl_en = 1'b1; excl_x = 6'd0;  excl_z = 6'd0;  base = 0;  end
                2: begin excl_en = 1'b1; excl_x = 6'd63; excl_z = 6'd63; base = 56; end
                3: begin
                    excl_en = 1'b1;
                    excl_x  = gcl_pkg::COORD_W'($urandom_range(56, 63));
                    excl_z  = gcl_pkg::COORD_W'($urandom_range(56, 63));
                    base    = 56;
                end
                4: begin excl_en = 1'b1; excl_x = 6'd63; excl_z = 6'd0;  base = 0;  end
                default: begin
                    excl_en  = 1'b0;
                    excl_x   = gcl_pkg::COORD_W'($urandom());
                    excl_z   = gcl_pkg::COORD_W'($urandom());
                    base     = 0;
                    idle_on  = 1'b0;
                    stall_on = 1'b0;
                end
            endcase
            write_reg(gcl_pkg::CFG_EXCL_EN, gcl_pkg::CFG_DATA_W'(excl_en));
            write_reg(gcl_pkg::CFG_EXCL_X,  gcl_pkg::CFG_DATA_W'(excl_x));
            write_reg(gcl_pkg::CFG_EXCL_Z,  gcl_pkg::CFG_DATA_W'(excl_z));
            // let the result side back up while commands keep coming
            if (phase == 2)
                hold_request = 1'b1;
            repeat (phase == 5 ? 2 : 3) grid_episode(base);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (tracker.faults == 0 && tracker.pending_answers.size() == 0)
            $display("grid_component_labeler_tb OK");
        else
            $display("grid_component_labeler_tb NOT OK");
        $finish;
    end

endmodule
